>>> sv/rsat_pkg.sv
// Package for the ROM slot address translator: sizes, codes, the job record
// passed from front to back, and the active slot count helper. No dependencies.
`default_nettype none
package rsat_pkg;

    localparam int MAX_SLOTS   = 16;
    localparam int OFFSET_BITS = 24;
    localparam int CMD_W       = 2;
    localparam int CPU_ADDR_W  = 16;
    localparam int IDX_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 5;

    localparam int ADDR_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
    // Window start plus the lengths of every slot, with headroom.
    localparam int ACC_W   = OFFSET_BITS + $clog2(MAX_SLOTS) + 2;

    localparam int JOB_Q_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(JOB_Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(JOB_Q_DEPTH + 1);

    localparam logic [CPU_ADDR_W-1:0] WINDOW_START = 16'h8000;
    localparam logic [CPU_ADDR_W:0]   WINDOW_END   = 17'h10000;

    typedef enum logic [CMD_W-1:0] {
        CMD_A2O   = 2'd0,
        CMD_O2A   = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OUTSIDE   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_WRITE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        JOB_A2O   = 2'd0,
        JOB_O2A   = 2'd1,
        JOB_WRITE = 2'd2,
        JOB_DONE  = 2'd3
    } t_kind;

    typedef enum logic {
        B_IDLE = 1'b0,
        B_WALK = 1'b1
    } t_back_state;

    typedef struct packed {
        t_kind                  kind;
        t_status                status;
        logic [CPU_ADDR_W-1:0]  addr;
        logic [OFFSET_BITS-1:0] ofs;
        logic [OFFSET_BITS-1:0] last;
        logic [ADDR_W-1:0]      idx;
    } t_job;

    // A slot count above the table size acts as the table size.
    function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] sc);
        if (32'(sc) > 32'(MAX_SLOTS)) begin
            return CNT_W'(MAX_SLOTS);
        end
        return CNT_W'(sc);
    endfunction

endpackage
`default_nettype wire

>>> sv/rsat_if.sv
// Channel interfaces of the ROM slot address translator: request items,
// result items and the slot count write channel. Depends on rsat_pkg.
`default_nettype none
interface rsat_in_if;
    logic                             valid;
    logic                             ready;
    logic [rsat_pkg::CMD_W-1:0]       command;
    logic [rsat_pkg::CPU_ADDR_W-1:0]  bus_address;
    logic [rsat_pkg::OFFSET_BITS-1:0] rom_offset;
    logic [rsat_pkg::IDX_W-1:0]       slot_index;
    logic [rsat_pkg::OFFSET_BITS-1:0] slot_first;
    logic [rsat_pkg::OFFSET_BITS-1:0] slot_last;

    modport source (output valid, command, bus_address, rom_offset, slot_index,
                    slot_first, slot_last, input ready);
    modport sink (input valid, command, bus_address, rom_offset, slot_index,
                  slot_first, slot_last, output ready);
endinterface

interface rsat_out_if;
    logic                             valid;
    logic                             ready;
    logic [rsat_pkg::STATUS_W-1:0]    status;
    logic [rsat_pkg::OFFSET_BITS-1:0] offset_result;
    logic [rsat_pkg::CPU_ADDR_W-1:0]  address_result;

    modport source (output valid, status, offset_result, address_result, input ready);
    modport sink (input valid, status, offset_result, address_result, output ready);
endinterface

interface rsat_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rsat_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> sv/rsat_fifo.sv
// Short job queue between the front and the back of the translator.
// Depends on rsat_pkg for the job record and the queue depth.
`default_nettype none
module rsat_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire rsat_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output rsat_pkg::t_job      o_job,
    output logic                o_empty
);

    rsat_pkg::t_job                  r_mem [rsat_pkg::JOB_Q_DEPTH];
    logic [rsat_pkg::Q_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [rsat_pkg::Q_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [rsat_pkg::Q_CNT_W-1:0]    r_count, n_count;

    assign o_full  = (32'(r_count) == rsat_pkg::JOB_Q_DEPTH);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (32'(r_wr_ptr) == rsat_pkg::JOB_Q_DEPTH - 1) ? '0 :
                       r_wr_ptr + rsat_pkg::Q_PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (32'(r_rd_ptr) == rsat_pkg::JOB_Q_DEPTH - 1) ? '0 :
                       r_rd_ptr + rsat_pkg::Q_PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + rsat_pkg::Q_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - rsat_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("job popped from an empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= rsat_pkg::JOB_Q_DEPTH)
        else $error("queue count beyond depth");

endmodule
`default_nettype wire

>>> sv/rsat_front.sv
// Front of the translator: holds the slot count register, accepts request
// items and classifies them into jobs. Depends on rsat_pkg and rsat_if.
`default_nettype none
module rsat_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    rsat_in_if.sink                          i_in,
    rsat_cfg_if.sink                         i_cfg,
    input  wire logic                        i_full,
    output logic                             o_push,
    output rsat_pkg::t_job                   o_job,
    output logic [rsat_pkg::CNT_W-1:0]       o_active
);

    logic [rsat_pkg::CFG_W-1:0] r_slot_count;
    logic                       w_bad_write;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign o_push      = i_in.valid && !i_full;
    assign o_active    = rsat_pkg::active_count(r_slot_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= '0;
        end else if (i_cfg.valid) begin
            r_slot_count <= i_cfg.data;
        end
    end

    assign w_bad_write = (32'(i_in.slot_index) >= 32'(o_active)) ||
                         (i_in.slot_last < i_in.slot_first);

    always_comb begin
        o_job        = '0;
        o_job.kind   = rsat_pkg::JOB_DONE;
        o_job.status = rsat_pkg::ST_OK;
        o_job.addr   = i_in.bus_address;
        o_job.ofs    = i_in.rom_offset;
        o_job.last   = i_in.slot_last;
        o_job.idx    = rsat_pkg::ADDR_W'(i_in.slot_index);
        unique case (rsat_pkg::t_cmd'(i_in.command))
            rsat_pkg::CMD_A2O: begin
                // Anything below the window start is rejected right here.
                if (i_in.bus_address < rsat_pkg::WINDOW_START) begin
                    o_job.status = rsat_pkg::ST_OUTSIDE;
                end else begin
                    o_job.kind = rsat_pkg::JOB_A2O;
                end
            end
            rsat_pkg::CMD_O2A: begin
                o_job.kind = rsat_pkg::JOB_O2A;
            end
            rsat_pkg::CMD_WRITE: begin
                o_job.ofs = i_in.slot_first;
                if (w_bad_write) begin
                    o_job.status = rsat_pkg::ST_BAD_WRITE;
                end else begin
                    o_job.kind = rsat_pkg::JOB_WRITE;
                end
            end
            default: begin
                o_job.status = rsat_pkg::ST_OK;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/rsat_back.sv
// Back of the translator: owns the slot memory, carries out writes and walks
// the slots one per cycle, and holds the result register. Depends on rsat_pkg and rsat_if.
`default_nettype none
module rsat_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [rsat_pkg::CNT_W-1:0]  i_active,
    input  wire rsat_pkg::t_job              i_job,
    input  wire logic                        i_empty,
    output logic                             o_pop,
    rsat_out_if.source                       o_out
);

    localparam int OB = rsat_pkg::OFFSET_BITS;
    localparam int AW = rsat_pkg::ACC_W;

    // Slot memory and its per-entry valid bits; an unwritten entry reads as zero.
    logic [OB-1:0]                 r_mem_first [rsat_pkg::MAX_SLOTS];
    logic [OB-1:0]                 r_mem_last  [rsat_pkg::MAX_SLOTS];
    logic [rsat_pkg::MAX_SLOTS-1:0] r_written;
    logic [OB-1:0]                 r_rd_first, r_rd_last;
    logic                          r_rd_valid;

    rsat_pkg::t_back_state         r_state, n_state;
    rsat_pkg::t_job                r_job;
    logic [rsat_pkg::ADDR_W-1:0]   r_idx;
    logic [AW-1:0]                 r_start;

    logic                          r_out_valid;
    rsat_pkg::t_status             r_out_status;
    logic [OB-1:0]                 r_out_offset;
    logic [rsat_pkg::CPU_ADDR_W-1:0] r_out_address;

    logic                          w_take, w_walk_job, w_we, w_load, w_done;
    logic [rsat_pkg::ADDR_W-1:0]   w_rd_addr;
    rsat_pkg::t_status             w_status;
    logic [OB-1:0]                 w_offset;
    logic [rsat_pkg::CPU_ADDR_W-1:0] w_address;

    logic [OB-1:0]                 w_f, w_l;
    logic [AW-1:0]                 w_end, w_next_start, w_a, w_addr_ext;
    logic                          w_hit_a2o, w_hit_o2a, w_last_slot, w_past_window;
    logic [OB-1:0]                 w_a2o_off;

    assign w_walk_job = (i_job.kind == rsat_pkg::JOB_A2O) ||
                        (i_job.kind == rsat_pkg::JOB_O2A);
    assign w_take     = (r_state == rsat_pkg::B_IDLE) && !i_empty &&
                        (!r_out_valid || o_out.ready);

    // One slot of the walk: the window span of the slot whose data is in hand.
    always_comb begin
        w_f           = r_rd_valid ? r_rd_first : '0;
        w_l           = r_rd_valid ? r_rd_last  : '0;
        w_addr_ext    = AW'(r_job.addr);
        w_end         = r_start + AW'(w_l - w_f);
        w_next_start  = w_end + AW'(1);
        w_hit_a2o     = (w_addr_ext >= r_start) && (w_addr_ext <= w_end);
        w_a2o_off     = OB'(AW'(w_f) + (w_addr_ext - r_start));
        w_hit_o2a     = (r_job.ofs >= w_f) && (r_job.ofs <= w_l);
        w_a           = r_start + AW'(r_job.ofs - w_f);
        w_past_window = (w_a >= AW'(rsat_pkg::WINDOW_END));
        w_last_slot   = ((32'(r_idx) + 32'd1) == 32'(i_active));
        w_done        = (r_job.kind == rsat_pkg::JOB_A2O) ? w_hit_a2o :
                        (w_hit_o2a || w_last_slot) ? 1'b1 : 1'b0;
        if (r_job.kind == rsat_pkg::JOB_A2O) begin
            w_done = w_hit_a2o || w_last_slot;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsat_pkg::B_IDLE: begin
                if (w_take && w_walk_job && (i_active != '0)) begin
                    n_state = rsat_pkg::B_WALK;
                end
            end
            rsat_pkg::B_WALK: begin
                if (w_done) begin
                    n_state = rsat_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = rsat_pkg::B_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        w_we      = 1'b0;
        w_load    = 1'b0;
        w_status  = rsat_pkg::ST_OK;
        w_offset  = '0;
        w_address = '0;
        w_rd_addr = '0;
        unique case (r_state)
            rsat_pkg::B_IDLE: begin
                o_pop = w_take;
                if (w_take) begin
                    unique case (i_job.kind)
                        rsat_pkg::JOB_WRITE: begin
                            w_we   = 1'b1;
                            w_load = 1'b1;
                        end
                        rsat_pkg::JOB_DONE: begin
                            w_load   = 1'b1;
                            w_status = i_job.status;
                        end
                        default: begin
                            if (i_active == '0) begin
                                w_load   = 1'b1;
                                w_status = rsat_pkg::ST_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            rsat_pkg::B_WALK: begin
                w_rd_addr = r_idx + rsat_pkg::ADDR_W'(1);
                if (r_job.kind == rsat_pkg::JOB_A2O) begin
                    if (w_hit_a2o) begin
                        w_load   = 1'b1;
                        w_offset = w_a2o_off;
                    end else if (w_last_slot) begin
                        w_load   = 1'b1;
                        w_status = rsat_pkg::ST_NOT_FOUND;
                    end
                end else begin
                    if (w_hit_o2a) begin
                        w_load = 1'b1;
                        if (w_past_window) begin
                            w_status = rsat_pkg::ST_OUTSIDE;
                        end else begin
                            w_address = rsat_pkg::CPU_ADDR_W'(w_a);
                        end
                    end else if (w_last_slot) begin
                        w_load   = 1'b1;
                        w_status = rsat_pkg::ST_NOT_FOUND;
                    end
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_first[i_job.idx] <= i_job.ofs;
            r_mem_last[i_job.idx]  <= i_job.last;
        end
        r_rd_first <= r_mem_first[w_rd_addr];
        r_rd_last  <= r_mem_last[w_rd_addr];
        r_rd_valid <= r_written[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written   <= '0;
            r_state     <= rsat_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_we) begin
                r_written[i_job.idx] <= 1'b1;
            end
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job   <= i_job;
            r_idx   <= '0;
            r_start <= AW'(rsat_pkg::WINDOW_START);
        end else if (r_state == rsat_pkg::B_WALK) begin
            r_idx   <= r_idx + rsat_pkg::ADDR_W'(1);
            r_start <= w_next_start;
        end
        if (w_load) begin
            r_out_status  <= w_status;
            r_out_offset  <= w_offset;
            r_out_address <= w_address;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.offset_result  = r_out_offset;
    assign o_out.address_result = r_out_address;

    a_walk_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsat_pkg::B_WALK) |-> !r_out_valid)
        else $error("result register busy during a slot walk");
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsat_pkg::B_WALK) |-> (32'(r_idx) < 32'(i_active)))
        else $error("slot walk beyond the active slots");
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((32'(i_job.idx) < 32'(i_active)) && (i_job.last >= i_job.ofs)))
        else $error("slot write that should have been rejected");

endmodule
`default_nettype wire

>>> sv/rom_slot_address_translator_top.sv
// Top level of the ROM slot address translator: front, job queue and back.
// Depends on rsat_pkg, rsat_if, rsat_front, rsat_fifo and rsat_back.
//
// Request items enter a front stage that checks them against the slot count
// and the CPU window and queues them as jobs in a two-entry queue; the front
// keeps accepting while the back is busy until the queue is full. The back
// loads the result of a slot write, a rejected request or an unused command
// into its result register as it takes the job. A translation walks the slots
// serially through the slot memory, one entry read per cycle, up to and
// including the first hit and at most through the active slot count. The slot
// memory has a valid bit per entry cleared at reset, so unwritten slots read
// as zero without any clearing pass. The slot count is to be written through
// its own channel only while the block is idle; the block itself does not
// enforce this.
`default_nettype none
module rom_slot_address_translator_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rsat_in_if.sink   i_in,
    rsat_cfg_if.sink  i_cfg,
    rsat_out_if.source o_out
);

    logic                        w_push, w_pop, w_full, w_empty;
    rsat_pkg::t_job              w_job_in, w_job_out;
    logic [rsat_pkg::CNT_W-1:0]  w_active;

    rsat_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_job    (w_job_in),
        .o_active (w_active)
    );

    rsat_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty)
    );

    rsat_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_active (w_active),
        .i_job    (w_job_out),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for rom_slot_address_translator_top: directed and random request items
// checked against a translation model of the slot table kept inside the bench.
// Depends on rsat_pkg, the rsat channel interfaces and the top level of the block.
module testbench;
    import rsat_pkg::*;

    localparam int GAP_MAX       = 17;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 3000;
    localparam int PHASE_ITEMS   = 135;
    localparam int PRINT_CAP     = 200;

    typedef struct {
        t_cmd                   command;
        logic [CPU_ADDR_W-1:0]  bus_address;
        logic [OFFSET_BITS-1:0] rom_offset;
        logic [IDX_W-1:0]       slot_index;
        logic [OFFSET_BITS-1:0] slot_first;
        logic [OFFSET_BITS-1:0] slot_last;
    } t_request;

    typedef struct {
        t_status                status;
        logic [OFFSET_BITS-1:0] offset_result;
        logic [CPU_ADDR_W-1:0]  address_result;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rsat_in_if  req_if ();
    rsat_out_if rsp_if ();
    rsat_cfg_if cfg_if ();

    rom_slot_address_translator_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .i_cfg   (cfg_if),
        .o_out   (rsp_if)
    );

    always #1 i_clk = ~i_clk;

    // Bench copy of the slot table and of the slot count register.
    logic [OFFSET_BITS-1:0] shadow_first [MAX_SLOTS];
    logic [OFFSET_BITS-1:0] shadow_last  [MAX_SLOTS];
    logic [CFG_W-1:0]       shadow_count;

    t_answer awaited_results [$];

    int   mismatches   = 0;
    int   items_sent   = 0;
    int   results_seen = 0;
    int   count_writes = 0;
    int   tx_gap       = 1;
    bit   tx_lowered   = 1'b1;
    bit   tx_burst     = 1'b0;
    bit   rx_burst     = 1'b0;
    bit   rx_hold      = 1'b0;
    event hold_request;

    function automatic int slots_in_use();
        return (shadow_count > MAX_SLOTS) ? MAX_SLOTS : int'(shadow_count);
    endfunction

    // Works out the result of one request item and applies slot writes to the
    // bench table.
    function automatic t_answer translate_item(input t_request rq);
        t_answer     ans;
        int          active;
        bit          hit;
        logic [31:0] base;
        logic [31:0] span_end;
        logic [31:0] cand;
        active             = slots_in_use();
        ans.status         = ST_OK;
        ans.offset_result  = '0;
        ans.address_result = '0;
        hit                = 1'b0;
        base               = 32'(WINDOW_START);
        case (rq.command)
            CMD_A2O: begin
                if (rq.bus_address < WINDOW_START) begin
                    ans.status = ST_OUTSIDE;
                end else begin
                    ans.status = ST_NOT_FOUND;
                    for (int i = 0; i < active && !hit; i++) begin
                        span_end = base + 32'(shadow_last[i]) - 32'(shadow_first[i]);
                        if (32'(rq.bus_address) >= base && 32'(rq.bus_address) <= span_end) begin
                            hit               = 1'b1;
                            ans.status        = ST_OK;
                            ans.offset_result = OFFSET_BITS'(32'(shadow_first[i])
                                                + 32'(rq.bus_address) - base);
                        end
                        base = span_end + 1;
                    end
                end
            end
            CMD_O2A: begin
                ans.status = ST_NOT_FOUND;
                for (int i = 0; i < active && !hit; i++) begin
                    if (rq.rom_offset >= shadow_first[i] && rq.rom_offset <= shadow_last[i]) begin
                        hit  = 1'b1;
                        cand = base + 32'(rq.rom_offset) - 32'(shadow_first[i]);
                        if (cand >= 32'(WINDOW_END)) begin
                            ans.status = ST_OUTSIDE;
                        end else begin
                            ans.status         = ST_OK;
                            ans.address_result = cand[CPU_ADDR_W-1:0];
                        end
                    end
                    base = base + 32'(shadow_last[i]) - 32'(shadow_first[i]) + 1;
                end
            end
            CMD_WRITE: begin
                if (int'(rq.slot_index) >= active || rq.slot_last < rq.slot_first) begin
                    ans.status = ST_BAD_WRITE;
                end else begin
                    shadow_first[rq.slot_index] = rq.slot_first;
                    shadow_last[rq.slot_index]  = rq.slot_last;
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    function automatic t_request pack_request(input t_cmd c, input logic [15:0] addr,
                                              input logic [23:0] ofs, input logic [3:0] idx,
                                              input logic [23:0] first, input logic [23:0] last);
        t_request rq;
        rq.command     = c;
        rq.bus_address = addr;
        rq.rom_offset  = ofs;
        rq.slot_index  = idx;
        rq.slot_first  = first;
        rq.slot_last   = last;
        return rq;
    endfunction

    function automatic t_request noise_request();
        return pack_request(t_cmd'($urandom_range(0, 3)), 16'($urandom),
                            24'($urandom), 4'($urandom), 24'($urandom), 24'($urandom));
    endfunction

    function automatic logic [OFFSET_BITS-1:0] random_span();
        case ($urandom_range(0, 3))
            0:       return OFFSET_BITS'($urandom_range(0, 15));
            1:       return OFFSET_BITS'($urandom_range(0, 1023));
            2:       return OFFSET_BITS'($urandom_range(0, 8191));
            default: return OFFSET_BITS'($urandom_range(0, 40000));
        endcase
    endfunction

    // A well-formed slot write; low offsets are favored so that slots overlap.
    function automatic t_request slot_write(input int idx);
        t_request               rq;
        logic [OFFSET_BITS-1:0] span;
        rq            = noise_request();
        span          = random_span();
        rq.command    = CMD_WRITE;
        rq.slot_index = IDX_W'(idx);
        if ($urandom_range(0, 2) == 0) begin
            rq.slot_first = OFFSET_BITS'($urandom_range(0, 65535));
        end else begin
            rq.slot_first = OFFSET_BITS'($urandom);
        end
        if (rq.slot_first > ~span) begin
            rq.slot_first = ~span;
        end
        rq.slot_last = rq.slot_first + span;
        return rq;
    endfunction

    function automatic t_request random_request();
        t_request    rq;
        int          active;
        int          pick;
        int          j;
        logic [31:0] window_used;
        logic [31:0] reach;
        rq          = noise_request();
        active      = slots_in_use();
        window_used = 0;
        for (int i = 0; i < active; i++) begin
            window_used += 32'(shadow_last[i]) - 32'(shadow_first[i]) + 1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // Raw noise, unused command included.
        end else if (pick < 28) begin
            if (active > 0 && $urandom_range(0, 4) != 0) begin
                rq = slot_write($urandom_range(0, active - 1));
            end else begin
                rq = slot_write($urandom_range(0, MAX_SLOTS - 1));
            end
            if ($urandom_range(0, 5) == 0) begin
                rq.slot_first = OFFSET_BITS'($urandom_range(1, 32'hFFFFFF));
                rq.slot_last  = OFFSET_BITS'($urandom_range(0, 32'(rq.slot_first) - 1));
            end
        end else if (pick < 64) begin
            rq.command = CMD_A2O;
            if ($urandom_range(0, 4) != 0) begin
                reach = (window_used + 8 > 32'h7FFF) ? 32'h7FFF : window_used + 8;
                rq.bus_address = CPU_ADDR_W'(32'(WINDOW_START) + $urandom_range(0, reach));
            end
        end else begin
            rq.command = CMD_O2A;
            if (active > 0 && $urandom_range(0, 4) != 0) begin
                j = $urandom_range(0, active - 1);
                case ($urandom_range(0, 3))
                    0: rq.rom_offset = shadow_first[j];
                    1: rq.rom_offset = shadow_last[j];
                    2: rq.rom_offset = shadow_last[j] + 1'b1;
                    default: rq.rom_offset = shadow_first[j] + OFFSET_BITS'($urandom_range(0,
                                             32'(shadow_last[j]) - 32'(shadow_first[j])));
                endcase
            end
        end
        return rq;
    endfunction

    task automatic report_mismatch(input string what, input int seq,
                                   input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
                     seq, what, got, want);
        end
    endtask

    // Offers one item, waits for its acceptance and records what it should give.
    // Valid stays high when the next item follows without a gap.
    task automatic send_item(input t_request rq);
        repeat (tx_gap) @(posedge i_clk);
        req_if.valid       <= 1'b1;
        req_if.command     <= rq.command;
        req_if.bus_address <= rq.bus_address;
        req_if.rom_offset  <= rq.rom_offset;
        req_if.slot_index  <= rq.slot_index;
        req_if.slot_first  <= rq.slot_first;
        req_if.slot_last   <= rq.slot_last;
        do @(posedge i_clk); while (!req_if.ready);
        awaited_results.push_back(translate_item(rq));
        items_sent++;
        tx_gap     = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
        tx_lowered = (tx_gap > 0);
        if (tx_lowered) begin
            req_if.valid <= 1'b0;
        end
    endtask

    task automatic stop_items();
        if (!tx_lowered) begin
            req_if.valid <= 1'b0;
            tx_lowered = 1'b1;
            tx_gap     = 1;
        end
    endtask

    task automatic wait_drained();
        stop_items();
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slot_count(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        shadow_count = value;
        count_writes++;
    endtask

    task automatic test_empty_table();
        write_slot_count(5'd0);
        send_item(pack_request(CMD_A2O, 16'h8000, 24'h0, 4'h0, 24'h0, 24'h0));
        send_item(pack_request(CMD_A2O, 16'h7FFF, 24'h0, 4'h0, 24'h0, 24'h0));
        send_item(pack_request(CMD_A2O, 16'h0000, 24'h0, 4'h0, 24'h0, 24'h0));
        send_item(pack_request(CMD_O2A, 16'h0000, 24'h0, 4'h0, 24'h0, 24'h0));
        // No slot is in use yet, so even slot zero is out of range.
        send_item(pack_request(CMD_WRITE, 16'h0000, 24'h0, 4'h0, 24'h10, 24'h20));
        send_item(pack_request(CMD_NONE, 16'hFFFF, 24'hFFFFFF, 4'hF, 24'hFFFFFF, 24'hFFFFFF));
    endtask

    task automatic test_directed_slots();
        // A count above the table size acts as the full table.
        write_slot_count(5'd31);
        send_item(pack_request(CMD_WRITE, 16'h0, 24'h0, 4'd0, 24'h000100, 24'h0001FF));
        send_item(pack_request(CMD_WRITE, 16'h0, 24'h0, 4'd1, 24'h000300, 24'h0002FF));
        send_item(pack_request(CMD_WRITE, 16'h0, 24'h0, 4'd1, 24'h000150, 24'h000150));
        send_item(pack_request(CMD_WRITE, 16'h0, 24'h0, 4'd15, 24'hFFFF00, 24'hFFFFFF));
        send_item(pack_request(CMD_A2O, 16'h8000, 24'h0, 4'h0, 24'h0, 24'h0));
        send_item(pack_request(CMD_A2O, 16'h80FF, 24'h0, 4'h0, 24'h0, 24'h0));
        send_item(pack_request(CMD_A2O, 16'h8100, 24'h0, 4'h0, 24'h0, 24'h0));
        send_item(pack_request(CMD_A2O, 16'h8101, 24'h0, 4'h0, 24'h0, 24'h0));
        // Offset 0x150 sits in slots zero and one; the lower index wins.
        send_item(pack_request(CMD_O2A, 16'h0, 24'h000150, 4'h0, 24'h0, 24'h0));
        send_item(pack_request(CMD_O2A, 16'h0, 24'h0001FF, 4'h0, 24'h0, 24'h0));
        send_item(pack_request(CMD_O2A, 16'h0, 24'hFFFFFF, 4'h0, 24'h0, 24'h0));
        // A slot that spans a whole window pushes later slots past 0xFFFF.
        send_item(pack_request(CMD_WRITE, 16'h0, 24'h0, 4'd2, 24'h000000, 24'h007FFF));
        send_item(pack_request(CMD_WRITE, 16'h0, 24'h0, 4'd3, 24'h200000, 24'h200010));
        send_item(pack_request(CMD_O2A, 16'h0, 24'h200005, 4'h0, 24'h0, 24'h0));
        send_item(pack_request(CMD_A2O, 16'hFFFF, 24'h0, 4'h0, 24'h0, 24'h0));
        write_slot_count(5'd16);
        send_item(pack_request(CMD_O2A, 16'h0, 24'h123456, 4'h0, 24'h0, 24'h0));
        send_item(pack_request(CMD_WRITE, 16'h0, 24'h0, 4'd15, 24'h000000, 24'hFFFFFF));
        send_item(pack_request(CMD_O2A, 16'h0, 24'h123456, 4'h0, 24'h0, 24'h0));
        write_slot_count(5'd1);
        send_item(pack_request(CMD_WRITE, 16'h0, 24'h0, 4'd1, 24'h000000, 24'h000000));
        send_item(pack_request(CMD_A2O, 16'h80FF, 24'h0, 4'h0, 24'h0, 24'h0));
        send_item(pack_request(CMD_A2O, 16'h8100, 24'h0, 4'h0, 24'h0, 24'h0));
    endtask

    // The receiver stops for a long stretch while items keep coming, so the
    // job queue fills and the input stalls.
    task automatic test_input_stall();
        write_slot_count(5'd16);
        tx_burst = 1'b1;
        -> hold_request;
        repeat (30) send_item(random_request());
        tx_burst = 1'b0;
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] settings [7];
        settings = '{5'd16, 5'd31, 5'd9, 5'd1, 5'd16, CFG_W'($urandom_range(0, 31)), 5'd4};
        for (int p = 0; p < 7; p++) begin
            write_slot_count(settings[p]);
            // Fill every slot in use before translating against the table.
            for (int s = 0; s < slots_in_use(); s++) begin
                send_item(slot_write(s));
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 50 == 0) begin
                    tx_burst = ($urandom_range(0, 3) == 0);
                end
                send_item(random_request());
            end
        end
        tx_burst = 1'b0;
    endtask

    initial begin : result_check
        t_answer want;
        int      gap;
        int      since_redraw;
        rsp_if.ready <= 1'b0;
        since_redraw = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (since_redraw == 0) begin
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            since_redraw = (since_redraw + 1) % 50;
            gap = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0 || rx_hold) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited, status", results_seen,
                                32'(rsp_if.status), 32'h0);
            end else begin
                want = awaited_results.pop_front();
                if (rsp_if.status !== want.status) begin
                    report_mismatch("status", results_seen, 32'(rsp_if.status),
                                    32'(want.status));
                end
                if (rsp_if.offset_result !== want.offset_result) begin
                    report_mismatch("offset_result", results_seen, 32'(rsp_if.offset_result),
                                    32'(want.offset_result));
                end
                if (rsp_if.address_result !== want.address_result) begin
                    report_mismatch("address_result", results_seen, 32'(rsp_if.address_result),
                                    32'(want.address_result));
                end
            end
        end
    end

    initial begin : hold_off
        @(hold_request);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                    || (cfg_if.valid && cfg_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : sequencer
        for (int i = 0; i < MAX_SLOTS; i++) begin
            shadow_first[i] = '0;
            shadow_last[i]  = '0;
        end
        shadow_count = '0;
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.command     <= CMD_A2O;
        req_if.bus_address <= '0;
        req_if.rom_offset  <= '0;
        req_if.slot_index  <= '0;
        req_if.slot_first  <= '0;
        req_if.slot_last   <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.data        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_directed_slots();
        test_input_stall();
        test_random_phases();
        wait_drained();
        $display("summary: %0d request items sent, %0d results checked, %0d slot count writes",
                 items_sent, results_seen, count_writes);
        $display("summary: all commands, window edges, overlaps, bad writes, input stall");
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
sv/rsat_pkg.sv
sv/rsat_if.sv
sv/rsat_fifo.sv
sv/rsat_front.sv
sv/rsat_back.sv
sv/rom_slot_address_translator_top.sv
tb/testbench.sv
